@@ rtl/core/vtyp_pkg.sv @@
// ----------------------------------------------------------------------------
// vtyp_pkg
// Shared widths, constants, angle table and item types for the vector to
// yaw / pitch angle converter.
// ----------------------------------------------------------------------------
package vtyp_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int ANGLE_FRAC_BITS = 8;

    localparam int CORDIC_STEPS = 30;
    localparam int NORM_TOP     = 30;            // normalized magnitude of a nonzero input lands in [2^30, 2^31)
    localparam int NORM_W       = NORM_TOP + 3;  // signed normalized component
    localparam int MAG_W        = NORM_W - 1;    // normalized magnitude
    localparam int SHIFT_W      = 5;
    localparam int CW           = NORM_W + 3;    // cordic datapath, room for gain
    localparam int ANG_W        = 32;            // binary angle, full turn = 2^32
    localparam int SQ_W         = 2 * ANG_W;
    localparam int SQ_ITERS     = SQ_W / 2;

    localparam int YAW_W     = ANGLE_FRAC_BITS + 9;
    localparam int PITCH_W   = ANGLE_FRAC_BITS + 10;
    localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
    localparam int PROD_W    = ANG_W + YAW_W;

    localparam logic [YAW_W-1:0] DEG_90  = YAW_W'(90 << ANGLE_FRAC_BITS);
    localparam logic [YAW_W-1:0] DEG_270 = YAW_W'(270 << ANGLE_FRAC_BITS);
    localparam logic [ANG_W-1:0] HALF_TURN = ANG_W'(1) << (ANG_W - 1);

    localparam int MQ_DEPTH = 4;
    localparam int OQ_DEPTH = 2;

    // atan(2^-i) in binary angle units
    localparam logic [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef struct packed {
        logic yaw_neg;  // x was negative, yaw gets a half turn added
        logic hz;       // zero horizontal part
        logic z_pos;
        logic x_zero;
        logic y_pos;
    } flags_t;

    typedef struct packed {
        logic        [MAG_W-1:0]  yaw_x;
        logic signed [NORM_W-1:0] yaw_y;
        logic        [MAG_W-1:0]  ax;
        logic        [MAG_W-1:0]  ay;
        logic signed [NORM_W-1:0] pz;
        flags_t                   flags;
    } mid_item_t;

endpackage

@@ rtl/core/vtyp_front.sv @@
// ----------------------------------------------------------------------------
// vtyp_front
// Classifies an incoming vector and normalizes its components for the yaw
// and the pitch paths before it enters the queue.
// ----------------------------------------------------------------------------
module vtyp_front (
    input  logic                                        push,
    output logic                                        full,
    input  logic signed [vtyp_pkg::COORD_WIDTH-1:0]     vec_x,
    input  logic signed [vtyp_pkg::COORD_WIDTH-1:0]     vec_y,
    input  logic signed [vtyp_pkg::COORD_WIDTH-1:0]     vec_z,
    input  logic                                        q_full,
    output logic                                        q_wr,
    output vtyp_pkg::mid_item_t                         q_item
);
    import vtyp_pkg::*;

    function automatic logic [SHIFT_W-1:0] norm_shift(input logic [MAG_W-1:0] m);
        logic [SHIFT_W-1:0] msb;
        msb = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (m[i])
                msb = SHIFT_W'(i);
        end
        if (msb < SHIFT_W'(NORM_TOP))
            return SHIFT_W'(NORM_TOP) - msb;
        return '0;
    endfunction

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [NORM_W-1:0] v);
        logic signed [NORM_W-1:0] n;
        n = -v;
        return v[NORM_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    logic signed [NORM_W-1:0] xe, ye, ze;
    logic signed [NORM_W-1:0] yx, yy, yx_neg, yy_neg, px, py, pz;
    logic        [MAG_W-1:0]  mx, my, mz, mxy, mall;
    logic        [SHIFT_W-1:0] sy, sp;
    logic                      x_zero, y_zero, yaw_neg;

    assign xe = NORM_W'(vec_x);
    assign ye = NORM_W'(vec_y);
    assign ze = NORM_W'(vec_z);

    assign mx   = abs_mag(xe);
    assign my   = abs_mag(ye);
    assign mz   = abs_mag(ze);
    assign mxy  = (mx > my) ? mx : my;
    assign mall = (mxy > mz) ? mxy : mz;

    assign sy = norm_shift(mxy);
    assign sp = norm_shift(mall);

    // yaw path: fold x into the right half plane
    assign yx      = xe <<< sy;
    assign yy      = ye <<< sy;
    assign yx_neg  = -yx;
    assign yy_neg  = -yy;
    assign yaw_neg = yx[NORM_W-1];

    assign px = xe <<< sp;
    assign py = ye <<< sp;
    assign pz = ze <<< sp;

    assign x_zero = (vec_x == '0);
    assign y_zero = (vec_y == '0);

    always_comb
    begin
        q_item.yaw_x         = yaw_neg ? yx_neg[MAG_W-1:0] : yx[MAG_W-1:0];
        q_item.yaw_y         = yaw_neg ? yy_neg : yy;
        q_item.ax            = abs_mag(px);
        q_item.ay            = abs_mag(py);
        q_item.pz            = pz;
        q_item.flags.yaw_neg = yaw_neg;
        q_item.flags.hz      = x_zero && y_zero;
        q_item.flags.z_pos   = !vec_z[COORD_WIDTH-1] && (vec_z != '0);
        q_item.flags.x_zero  = x_zero;
        q_item.flags.y_pos   = !vec_y[COORD_WIDTH-1] && !y_zero;
    end

    assign q_wr = push && !q_full;
    assign full = q_full;

endmodule

@@ rtl/core/vtyp_mid_queue.sv @@
// ----------------------------------------------------------------------------
// vtyp_mid_queue
// Short queue that decouples the classifying front from the arithmetic back.
// ----------------------------------------------------------------------------
module vtyp_mid_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  vtyp_pkg::mid_item_t  wr_item,
    input  logic                 rd,
    output vtyp_pkg::mid_item_t  rd_item,
    output logic                 full,
    output logic                 empty
);
    import vtyp_pkg::*;

    localparam int PTR_W = $clog2(MQ_DEPTH);
    localparam int CNT_W = $clog2(MQ_DEPTH + 1);

    mid_item_t          mem [MQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(wr) - CNT_W'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wr_ptr_reg] <= wr_item;
    end

    assign rd_item = mem[rd_ptr_reg];
    assign full    = (cnt_reg == CNT_W'(MQ_DEPTH));
    assign empty   = (cnt_reg == '0);

endmodule

@@ rtl/core/vtyp_cordic.sv @@
// ----------------------------------------------------------------------------
// vtyp_cordic
// Unrolled vectoring cordic, one micro-rotation per stage, giving atan2(y,x)
// in binary angle units for x >= 0.
// ----------------------------------------------------------------------------
module vtyp_cordic (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [vtyp_pkg::CW-1:0]      in_x,
    input  logic signed [vtyp_pkg::CW-1:0]      in_y,
    output logic        [vtyp_pkg::ANG_W-1:0]   z_out
);
    import vtyp_pkg::*;

    logic signed [CW-1:0]    x_reg [CORDIC_STEPS-1];
    logic signed [CW-1:0]    y_reg [CORDIC_STEPS-1];
    logic        [ANG_W-1:0] z_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_stage
        logic signed [CW-1:0]    xi, yi;
        logic        [ANG_W-1:0] zi;

        if (i == 0)
        begin : g_first
            assign xi = in_x;
            assign yi = in_y;
            assign zi = '0;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                z_reg[i] <= yi[CW-1] ? zi - ATAN_TAB[i] : zi + ATAN_TAB[i];
        end

        // the last stage only needs the angle
        if (i < CORDIC_STEPS - 1)
        begin : g_xy
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!yi[CW-1])
                    begin
                        x_reg[i] <= xi + (yi >>> i);
                        y_reg[i] <= yi - (xi >>> i);
                    end
                    else
                    begin
                        x_reg[i] <= xi - (yi >>> i);
                        y_reg[i] <= yi + (xi >>> i);
                    end
                end
            end
        end
    end

    assign z_out = z_reg[CORDIC_STEPS-1];

endmodule

@@ rtl/core/vtyp_back.sv @@
// ----------------------------------------------------------------------------
// vtyp_back
// Pipelined arithmetic: horizontal magnitude by squares and a digit-per-stage
// square root, two cordic pipelines, degree conversion and the result queue.
// ----------------------------------------------------------------------------
module vtyp_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_empty,
    input  vtyp_pkg::mid_item_t                    q_item,
    output logic                                   q_rd,
    output logic                                   empty,
    input  logic                                   pop,
    output logic        [vtyp_pkg::YAW_W-1:0]      yaw_angle,
    output logic signed [vtyp_pkg::PITCH_W-1:0]    neg_pitch_angle
);
    import vtyp_pkg::*;

    typedef struct packed {
        logic        [MAG_W-1:0]  yaw_x;
        logic signed [NORM_W-1:0] yaw_y;
        logic signed [NORM_W-1:0] pz;
        flags_t                   flags;
    } side_t;

    typedef struct packed {
        logic [YAW_W-1:0]   yaw;
        logic [PITCH_W-1:0] negp;
    } result_t;

    localparam int IT0  = 2;
    localparam int RND  = IT0 + SQ_ITERS;
    localparam int COR0 = RND + 1;
    localparam int DEG  = COR0 + CORDIC_STEPS;
    localparam int TOT  = DEG + 1;

    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    logic           en;
    logic [TOT-1:0] vld_reg;

    // stall the whole pipeline only when the result queue is full
    logic oq_full;
    assign en   = !oq_full;
    assign q_rd = en && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TOT-2:0], !q_empty};
    end

    side_t             side0_reg, side1_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg, n1_reg;
    logic [SQ_W-1:0]   sqx, sqy;

    assign sqx = q_item.ax * q_item.ax;
    assign sqy = q_item.ay * q_item.ay;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg   <= sqx;
            sqy_reg   <= sqy;
            side0_reg <= '{yaw_x: q_item.yaw_x, yaw_y: q_item.yaw_y,
                           pz: q_item.pz, flags: q_item.flags};
            n1_reg    <= sqx_reg + sqy_reg;
            side1_reg <= side0_reg;
        end
    end

    // square root, one result bit per stage
    logic [SQ_W-1:0] n_it   [SQ_ITERS];
    logic [SQ_W-1:0] res_it [SQ_ITERS];
    side_t           side_it [SQ_ITERS];

    for (genvar k = 0; k < SQ_ITERS; k++)
    begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] n_i, res_i, t;
        side_t           side_i;

        if (k == 0)
        begin : g_first
            assign n_i    = n1_reg;
            assign res_i  = '0;
            assign side_i = side1_reg;
        end
        else
        begin : g_rest
            assign n_i    = n_it[k-1];
            assign res_i  = res_it[k-1];
            assign side_i = side_it[k-1];
        end

        assign t = res_i + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_i >= t)
                begin
                    n_it[k]   <= n_i - t;
                    res_it[k] <= (res_i >> 1) + BIT;
                end
                else
                begin
                    n_it[k]   <= n_i;
                    res_it[k] <= res_i >> 1;
                end
                side_it[k] <= side_i;
            end
        end
    end

    logic [MAG_W:0] r_reg;
    side_t          side_r_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg      <= (MAG_W+1)'(res_it[SQ_ITERS-1])
                        + (MAG_W+1)'(n_it[SQ_ITERS-1] > res_it[SQ_ITERS-1]);
            side_r_reg <= side_it[SQ_ITERS-1];
        end
    end

    // both angle pipelines start together
    logic signed [CW-1:0]    yx_in, yy_in, px_in, py_in;
    logic        [ANG_W-1:0] yaw_z, pitch_z;

    assign yx_in = $signed(CW'(side_r_reg.yaw_x));
    assign yy_in = CW'($signed(side_r_reg.yaw_y));
    assign px_in = $signed(CW'(r_reg));
    assign py_in = CW'($signed(side_r_reg.pz));

    vtyp_cordic u_yaw_cordic (
        .clk   (clk),
        .en    (en),
        .in_x  (yx_in),
        .in_y  (yy_in),
        .z_out (yaw_z)
    );

    vtyp_cordic u_pitch_cordic (
        .clk   (clk),
        .en    (en),
        .in_x  (px_in),
        .in_y  (py_in),
        .z_out (pitch_z)
    );

    flags_t fc_reg [CORDIC_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fc_reg[0] <= side_r_reg.flags;
            for (int i = 1; i < CORDIC_STEPS; i++)
                fc_reg[i] <= fc_reg[i-1];
        end
    end

    // degree conversion
    logic [ANG_W-1:0]  yaw_full;
    logic [PROD_W-1:0] prod_y_reg, prod_p_reg, sum_y, sum_p;
    flags_t            flags_d_reg;
    logic [YAW_W-1:0]  ry, rp, ry_w, rp_w, yaw_v, pitch_v;

    assign yaw_full = yaw_z + (fc_reg[CORDIC_STEPS-1].yaw_neg ? HALF_TURN : '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_y_reg  <= PROD_W'(yaw_full) * PROD_W'(FULL_TURN);
            prod_p_reg  <= PROD_W'(pitch_z) * PROD_W'(FULL_TURN);
            flags_d_reg <= fc_reg[CORDIC_STEPS-1];
        end
    end

    assign sum_y = prod_y_reg + PROD_W'(HALF_TURN);
    assign sum_p = prod_p_reg + PROD_W'(HALF_TURN);
    assign ry    = sum_y[PROD_W-1:ANG_W];
    assign rp    = sum_p[PROD_W-1:ANG_W];
    // a value that rounds up to a full turn wraps to zero
    assign ry_w  = (ry >= YAW_W'(FULL_TURN)) ? ry - YAW_W'(FULL_TURN) : ry;
    assign rp_w  = (rp >= YAW_W'(FULL_TURN)) ? rp - YAW_W'(FULL_TURN) : rp;

    always_comb
    begin
        if (flags_d_reg.hz)
            yaw_v = '0;
        else if (flags_d_reg.x_zero)
            yaw_v = flags_d_reg.y_pos ? DEG_90 : DEG_270;
        else
            yaw_v = ry_w;

        if (flags_d_reg.hz)
            pitch_v = flags_d_reg.z_pos ? DEG_90 : DEG_270;
        else
            pitch_v = rp_w;
    end

    // result queue
    result_t              oq_mem [OQ_DEPTH];
    result_t              oq_in;
    logic                 oq_push, oq_pop;
    logic [OQ_PTR_W-1:0]  oq_wr_reg, oq_rd_reg;
    logic [OQ_CNT_W-1:0]  oq_cnt_reg;

    assign oq_in.yaw  = yaw_v;
    assign oq_in.negp = PITCH_W'(0) - PITCH_W'(pitch_v);
    assign oq_push    = en && vld_reg[DEG];
    assign oq_pop     = pop && !empty;
    assign oq_full    = (oq_cnt_reg == OQ_CNT_W'(OQ_DEPTH));
    assign empty      = (oq_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (oq_push)
                oq_wr_reg <= oq_wr_reg + OQ_PTR_W'(1);
            if (oq_pop)
                oq_rd_reg <= oq_rd_reg + OQ_PTR_W'(1);
            oq_cnt_reg <= oq_cnt_reg + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_mem[oq_wr_reg] <= oq_in;
    end

    assign yaw_angle       = oq_mem[oq_rd_reg].yaw;
    assign neg_pitch_angle = $signed(oq_mem[oq_rd_reg].negp);

    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> !oq_full)
        else $error("result written into a full queue");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_rd_only_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |=> vld_reg[0])
        else $error("popped transaction lost at pipeline entry");

endmodule

@@ rtl/core/vector_to_yaw_pitch_angles.sv @@
// ----------------------------------------------------------------------------
// vector_to_yaw_pitch_angles
// Direction vector to yaw and negated pitch in degrees, fixed point.
// ----------------------------------------------------------------------------
// pipeline: an accepted transaction passes the squares, the 32-stage square root
//   and the 30-stage cordic before degree conversion and the result queue
// throughput: one transaction per cycle while results are taken
// reset: rst_n clears both queues and all pipeline valid bits at once
module vector_to_yaw_pitch_angles (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    output logic                                     full,
    input  logic signed [vtyp_pkg::COORD_WIDTH-1:0]  vec_x,
    input  logic signed [vtyp_pkg::COORD_WIDTH-1:0]  vec_y,
    input  logic signed [vtyp_pkg::COORD_WIDTH-1:0]  vec_z,
    output logic                                     empty,
    input  logic                                     pop,
    output logic        [vtyp_pkg::YAW_W-1:0]        yaw_angle,
    output logic signed [vtyp_pkg::PITCH_W-1:0]      neg_pitch_angle
);
    import vtyp_pkg::*;

    mid_item_t wr_item, rd_item;
    logic      q_wr, q_rd, q_full, q_empty;

    vtyp_front u_front (
        .push   (push),
        .full   (full),
        .vec_x  (vec_x),
        .vec_y  (vec_y),
        .vec_z  (vec_z),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_item (wr_item)
    );

    vtyp_mid_queue u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_item (wr_item),
        .rd      (q_rd),
        .rd_item (rd_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    vtyp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_item          (rd_item),
        .q_rd            (q_rd),
        .empty           (empty),
        .pop             (pop),
        .yaw_angle       (yaw_angle),
        .neg_pitch_angle (neg_pitch_angle)
    );

endmodule
